// ----- rtl/vat3d_pkg.sv -----
package vat3d_pkg;

  // Field widths of the vertex words and the configuration port.
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned PROD_W     = 2 * COORD_W;
  localparam int unsigned LIN_W      = COORD_W + 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned MODE_W     = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [LIN_W-1:0]   lin_t;

  // Reset value of the coefficient registers: 1.0 in Q16.16.
  localparam coord_t COEF_RESET = 32'sd65536;

  typedef enum logic [MODE_W-1:0] {
    MODE_ROT_X = 3'd0,
    MODE_ROT_Y = 3'd1,
    MODE_ROT_Z = 3'd2,
    MODE_TRAN  = 3'd3,
    MODE_SCALE = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_COEF_A = 2'd1,
    REG_COEF_B = 2'd2,
    REG_COEF_C = 2'd3
  } cfg_reg_e;

  // Per-axis operation: a plain sum of two operands, or the sum or the
  // difference of two shifted products.
  typedef enum logic [1:0] {
    AX_LIN  = 2'd0,
    AX_PADD = 2'd1,
    AX_PSUB = 2'd2
  } axis_op_e;

  typedef struct packed {
    axis_op_e op;
    coord_t   a0;
    coord_t   b0;
    coord_t   a1;
    coord_t   b1;
  } axis_opnd_t;

  typedef struct packed {
    axis_op_e op;
    prod_t    p0;
    prod_t    p1;
    lin_t     lin;
  } axis_prod_t;

  typedef struct packed {
    axis_opnd_t [2:0] ax;
    logic             last;
  } stage1_t;

  typedef struct packed {
    axis_prod_t [2:0] ax;
    logic             last;
  } stage2_t;

endpackage

// ----- rtl/vat3d_if.sv -----
interface vat3d_in_if import vat3d_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t x_in;
  coord_t y_in;
  coord_t z_in;
  logic   last_in;

  modport source (output valid, x_in, y_in, z_in, last_in, input ready);
  modport sink   (input valid, x_in, y_in, z_in, last_in, output ready);
endinterface

interface vat3d_out_if import vat3d_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t x_out;
  coord_t y_out;
  coord_t z_out;
  logic   last_out;

  modport source (output valid, x_out, y_out, z_out, last_out, input ready);
  modport sink   (input valid, x_out, y_out, z_out, last_out, output ready);
endinterface

// ----- rtl/vertex_affine_transform_3d_unit.sv -----
// Homogeneous 3-D vertex transform. Each input word carries one vertex in
// signed fixed point with FRAC_BITS fraction bits; the block returns the
// vertex rotated about X, Y or Z, translated, or scaled per axis, as the
// mode register selects (mode codes 5 to 7 pass the vertex through). For a
// rotation, software writes the cosine of the angle into coef_a and the sine
// into coef_b. Every product is shifted right by FRAC_BITS rounding toward
// minus infinity, and each result coordinate saturates to 32 bits. The block
// takes one vertex per clock cycle unless the output stalls, and passes it
// through the three register stages of the datapath: operand selection,
// the six 32x32 multipliers, and the shift, add and saturation. When the
// output word is not taken, the whole pipeline holds and the input ready
// drops. Configuration is written through a plain write port and must only
// change while no vertex is in flight.
module vertex_affine_transform_3d_unit import vat3d_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  vat3d_in_if.sink              in_i,
  vat3d_out_if.source           out_o
);

  localparam int unsigned SUM_W = PROD_W + 1;
  localparam logic signed [SUM_W-1:0] SAT_MAX = 65'sd2147483647;
  localparam logic signed [SUM_W-1:0] SAT_MIN = -65'sd2147483648;

  // Configuration registers.
  mode_e  mode_q;
  coord_t coef_a_q;
  coord_t coef_b_q;
  coord_t coef_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_SCALE;
      coef_a_q <= COEF_RESET;
      coef_b_q <= COEF_RESET;
      coef_c_q <= COEF_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MODE:   mode_q   <= mode_e'(cfg_data_i[MODE_W-1:0]);
        REG_COEF_A: coef_a_q <= coord_t'(cfg_data_i[COORD_W-1:0]);
        REG_COEF_B: coef_b_q <= coord_t'(cfg_data_i[COORD_W-1:0]);
        REG_COEF_C: coef_c_q <= coord_t'(cfg_data_i[COORD_W-1:0]);
        default: ;
      endcase
    end
  end

  // Pipeline control. All stages move together; the pipeline advances
  // whenever the output register is empty or its word is being taken.
  logic adv;
  logic v1_q, v2_q, v3_q;

  assign adv         = !v3_q || out_o.ready;
  assign in_i.ready  = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 1: map the mode onto per-axis operand pairs. Every axis computes
  // either a0 + b0, or [a0*b0] +/- [a1*b1]. Pass-through is a0 + 0, and a
  // single product uses a zero second pair.
  stage1_t s1_d, s1_q;
  coord_t  vx, vy, vz;

  assign vx = in_i.x_in;
  assign vy = in_i.y_in;
  assign vz = in_i.z_in;

  always_comb begin
    s1_d.last  = in_i.last_in;
    s1_d.ax[0] = '{op: AX_LIN, a0: vx, b0: '0, a1: '0, b1: '0};
    s1_d.ax[1] = '{op: AX_LIN, a0: vy, b0: '0, a1: '0, b1: '0};
    s1_d.ax[2] = '{op: AX_LIN, a0: vz, b0: '0, a1: '0, b1: '0};
    unique case (mode_q)
      MODE_ROT_X: begin
        s1_d.ax[1] = '{op: AX_PSUB, a0: vy, b0: coef_a_q, a1: vz, b1: coef_b_q};
        s1_d.ax[2] = '{op: AX_PADD, a0: vy, b0: coef_b_q, a1: vz, b1: coef_a_q};
      end
      MODE_ROT_Y: begin
        s1_d.ax[0] = '{op: AX_PSUB, a0: vx, b0: coef_a_q, a1: vz, b1: coef_b_q};
        s1_d.ax[2] = '{op: AX_PADD, a0: vx, b0: coef_b_q, a1: vz, b1: coef_a_q};
      end
      MODE_ROT_Z: begin
        s1_d.ax[0] = '{op: AX_PADD, a0: vx, b0: coef_a_q, a1: vy, b1: coef_b_q};
        s1_d.ax[1] = '{op: AX_PSUB, a0: vy, b0: coef_a_q, a1: vx, b1: coef_b_q};
      end
      MODE_TRAN: begin
        s1_d.ax[0].b0 = coef_a_q;
        s1_d.ax[1].b0 = coef_b_q;
        s1_d.ax[2].b0 = coef_c_q;
      end
      MODE_SCALE: begin
        s1_d.ax[0] = '{op: AX_PADD, a0: vx, b0: coef_a_q, a1: '0, b1: '0};
        s1_d.ax[1] = '{op: AX_PADD, a0: vy, b0: coef_b_q, a1: '0, b1: '0};
        s1_d.ax[2] = '{op: AX_PADD, a0: vz, b0: coef_c_q, a1: '0, b1: '0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
    end
  end

  // Stage 2: the full-width products and the linear sum of each axis.
  stage2_t s2_d, s2_q;

  always_comb begin
    s2_d.last = s1_q.last;
    for (int k = 0; k < 3; k++) begin
      s2_d.ax[k].op  = s1_q.ax[k].op;
      s2_d.ax[k].p0  = prod_t'(s1_q.ax[k].a0 * s1_q.ax[k].b0);
      s2_d.ax[k].p1  = prod_t'(s1_q.ax[k].a1 * s1_q.ax[k].b1);
      s2_d.ax[k].lin = lin_t'({s1_q.ax[k].a0[COORD_W-1], s1_q.ax[k].a0})
                     + lin_t'({s1_q.ax[k].b0[COORD_W-1], s1_q.ax[k].b0});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q <= s2_d;
    end
  end

  // Stage 3: floor shift of the products, combine, saturate.
  function automatic coord_t sat_coord(logic signed [SUM_W-1:0] v);
    coord_t r;
    if (v > SAT_MAX) begin
      r = coord_t'(SAT_MAX[COORD_W-1:0]);
    end else if (v < SAT_MIN) begin
      r = coord_t'(SAT_MIN[COORD_W-1:0]);
    end else begin
      r = coord_t'(v[COORD_W-1:0]);
    end
    return r;
  endfunction

  coord_t res_d [3];
  coord_t res_q [3];
  logic   last_q;

  always_comb begin
    prod_t                   sh0;
    prod_t                   sh1;
    logic signed [SUM_W-1:0] sum;
    for (int k = 0; k < 3; k++) begin
      sh0 = s2_q.ax[k].p0 >>> FRAC_BITS;
      sh1 = s2_q.ax[k].p1 >>> FRAC_BITS;
      unique case (s2_q.ax[k].op)
        AX_PADD: sum = {sh0[PROD_W-1], sh0} + {sh1[PROD_W-1], sh1};
        AX_PSUB: sum = {sh0[PROD_W-1], sh0} - {sh1[PROD_W-1], sh1};
        default: sum = {{(SUM_W-LIN_W){s2_q.ax[k].lin[LIN_W-1]}}, s2_q.ax[k].lin};
      endcase
      res_d[k] = sat_coord(sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q  <= res_d;
      last_q <= s2_q.last;
    end
  end

  assign out_o.valid    = v3_q;
  assign out_o.x_out    = res_q[0];
  assign out_o.y_out    = res_q[1];
  assign out_o.z_out    = res_q[2];
  assign out_o.last_out = last_q;

  // A word in stage 1 reaches stage 2 whenever the pipeline advances.
  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && v1_q |=> v2_q)
    else $error("stage 1 word lost on advance");

  // While the pipeline holds, no stage gains or loses a word.
  a_hold_valids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v1_q) && $stable(v2_q) && $stable(v3_q))
    else $error("valid bits changed during stall");

  // The end-of-figure flag moves from stage 2 to the output with its vertex.
  a_last_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && v2_q |=> v3_q && (out_o.last_out == $past(s2_q.last)))
    else $error("last flag did not follow its vertex");

endmodule
